### src/cordic_vectoring_atan_magnitude_macros.svh
// ----------------------------------------------------------------------------
// cordic vectoring assertion macros
// shared assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef CORDIC_VECTORING_ATAN_MAGNITUDE_MACROS_SVH
`define CORDIC_VECTORING_ATAN_MAGNITUDE_MACROS_SVH

`ifndef ASSERT_OFF

// clocked assertion, disabled while reset is asserted
`define CVAM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CVAM_ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CVAM_ASSERT(label, clk, rst_n, prop, msg)
`define CVAM_ASSERT_ANY(label, clk, prop, msg)

`endif

`endif

### src/cvam_pkg.sv
// ----------------------------------------------------------------------------
// cvam_pkg
// widths, constants, word type and arctangent table for the cordic pipeline
// ----------------------------------------------------------------------------
package cvam_pkg;

    // pipeline depth and coordinate width
    localparam int ITERATIONS  = 20;
    localparam int COORD_WIDTH = 16;

    // fixed-point formats
    localparam int GUARD_BITS = 8;
    localparam int DATA_W     = COORD_WIDTH + GUARD_BITS + 3;
    localparam int ANG_W      = 27;
    localparam int SHIFT_W    = $clog2(ITERATIONS + 1);

    // output field widths
    localparam int ANGLE_OUT_W = 26;
    localparam int MAG_OUT_W   = 16;

    // gain correction: round(K * 2^32), magnitude = (x * gain) >> (32 + guard)
    localparam int                GAIN_W     = 32;
    localparam logic [GAIN_W-1:0] GAIN_Q32   = 32'h9B74EDA8;
    localparam int                PROD_W     = DATA_W - 1 + GAIN_W;
    localparam int                MAG_SHIFT  = GAIN_W + GUARD_BITS;
    localparam logic [PROD_W-1:0] MAG_MAX    = PROD_W'(65535);

    // angle constants in degrees * 65536
    localparam logic signed [ANG_W-1:0] HALF_TURN = 27'sd11796480;
    localparam logic signed [ANG_W-1:0] ANGLE_MIN = -27'sd5900000;
    localparam logic signed [ANG_W-1:0] ANGLE_MAX = 27'sd17700000;

    // atan(2^-i) in degrees * 65536, rounded to nearest
    localparam int ATAN_LEN = 24;
    localparam logic signed [ANG_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
        27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
        27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
        27'sd917,     27'sd458,     27'sd229,    27'sd115,
        27'sd57,      27'sd29,      27'sd14,     27'sd7,
        27'sd4,       27'sd2,       27'sd1,      27'sd0
    };

    // word handed from cell to cell
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [ANG_W-1:0]  ang;
        logic                     flip;
    } data_t;

    // rotation angle of step i, zero past the end of the table
    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        logic signed [ANG_W-1:0] a;
        a = '0;
        if (i < ATAN_LEN) begin
            a = ATAN_TABLE[i];
        end
        return a;
    endfunction

endpackage

### src/cvam_pre.sv
// ----------------------------------------------------------------------------
// cvam_pre
// input stage: folds the vector into the right half plane and adds guard bits
// ----------------------------------------------------------------------------
module cvam_pre (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [15:0]                    x_coord,
    input  logic signed [15:0]                    y_coord,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output cvam_pkg::data_t                       out_data
);

    logic                     valid_reg;
    cvam_pkg::data_t          data_reg;
    cvam_pkg::data_t          data_next;
    logic [cvam_pkg::COORD_WIDTH-1:0] x_raw;
    logic [cvam_pkg::COORD_WIDTH-1:0] y_raw;
    logic signed [cvam_pkg::DATA_W-1:0] x_ext;
    logic signed [cvam_pkg::DATA_W-1:0] y_ext;
    logic signed [cvam_pkg::DATA_W-1:0] x_fold;
    logic signed [cvam_pkg::DATA_W-1:0] y_fold;

    // take the words as coordinate-width two's complement
    assign x_raw = cvam_pkg::COORD_WIDTH'($unsigned(x_coord));
    assign y_raw = cvam_pkg::COORD_WIDTH'($unsigned(y_coord));
    assign x_ext = cvam_pkg::DATA_W'($signed(x_raw));
    assign y_ext = cvam_pkg::DATA_W'($signed(y_raw));

    // negate when x is not positive, then scale up by the guard bits
    always_comb
    begin
        data_next.flip = (x_ext <= 0);
        x_fold = data_next.flip ? -x_ext : x_ext;
        y_fold = data_next.flip ? -y_ext : y_ext;
        data_next.x   = x_fold <<< cvam_pkg::GUARD_BITS;
        data_next.y   = y_fold <<< cvam_pkg::GUARD_BITS;
        data_next.ang = '0;
    end

    // stage handshake: load when empty or when the word moves on
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### src/cvam_cell.sv
// ----------------------------------------------------------------------------
// cvam_cell
// one cordic micro-rotation: shift-add toward the x axis and angle update
// ----------------------------------------------------------------------------
module cvam_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [cvam_pkg::SHIFT_W-1:0]          shift,
    input  logic signed [cvam_pkg::ANG_W-1:0]     atan_step,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  cvam_pkg::data_t                       in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output cvam_pkg::data_t                       out_data
);

    logic                               valid_reg;
    cvam_pkg::data_t                    data_reg;
    cvam_pkg::data_t                    data_next;
    logic signed [cvam_pkg::DATA_W-1:0] dx;
    logic signed [cvam_pkg::DATA_W-1:0] dy;

    // arithmetic shifts round toward minus infinity
    assign dx = in_data.y >>> shift;
    assign dy = in_data.x >>> shift;

    // rotate by the sign of y
    always_comb
    begin
        data_next.flip = in_data.flip;
        if (in_data.y < 0) begin
            data_next.x   = in_data.x - dx;
            data_next.y   = in_data.y + dy;
            data_next.ang = in_data.ang - atan_step;
        end else begin
            data_next.x   = in_data.x + dx;
            data_next.y   = in_data.y - dy;
            data_next.ang = in_data.ang + atan_step;
        end
    end

    // stage handshake
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### src/cvam_post.sv
// ----------------------------------------------------------------------------
// cvam_post
// gain multiply, half-turn correction, then angle clamp and magnitude output
// ----------------------------------------------------------------------------
module cvam_post (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  cvam_pkg::data_t                       in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [25:0]                    angle_deg,
    output logic [15:0]                           magnitude
);

    // multiply stage
    logic                                 mul_valid_reg;
    logic                                 mul_ready;
    logic [cvam_pkg::PROD_W-1:0]          prod_reg;
    logic [cvam_pkg::PROD_W-1:0]          prod_next;
    logic signed [cvam_pkg::ANG_W-1:0]    ang_reg;
    logic signed [cvam_pkg::ANG_W-1:0]    ang_next;

    // output stage
    logic                                 out_valid_reg;
    logic signed [25:0]                   angle_reg;
    logic signed [25:0]                   angle_next;
    logic [15:0]                          mag_reg;
    logic [15:0]                          mag_next;
    logic [cvam_pkg::PROD_W-1:0]          mag_full;
    logic signed [cvam_pkg::ANG_W-1:0]    ang_clamp;

    // gain product, zero for a non-positive x
    always_comb
    begin
        prod_next = '0;
        if (in_data.x > 0) begin
            prod_next = cvam_pkg::PROD_W'(in_data.x[cvam_pkg::DATA_W-2:0])
                      * cvam_pkg::PROD_W'(cvam_pkg::GAIN_Q32);
        end
        ang_next = in_data.flip ? in_data.ang + cvam_pkg::HALF_TURN : in_data.ang;
    end

    assign in_ready = !mul_valid_reg || mul_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mul_valid_reg <= 1'b0;
        end else if (in_ready) begin
            mul_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            prod_reg <= prod_next;
            ang_reg  <= ang_next;
        end
    end

    // clamp the angle and saturate the magnitude
    always_comb
    begin
        mag_full  = prod_reg >> cvam_pkg::MAG_SHIFT;
        mag_next  = (mag_full > cvam_pkg::MAG_MAX) ? 16'hFFFF : mag_full[15:0];
        ang_clamp = ang_reg;
        if (ang_reg < cvam_pkg::ANGLE_MIN) begin
            ang_clamp = cvam_pkg::ANGLE_MIN;
        end else if (ang_reg > cvam_pkg::ANGLE_MAX) begin
            ang_clamp = cvam_pkg::ANGLE_MAX;
        end
        angle_next = ang_clamp[25:0];
    end

    assign mul_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (mul_ready) begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_valid_reg && mul_ready) begin
            angle_reg <= angle_next;
            mag_reg   <= mag_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign angle_deg = angle_reg;
    assign magnitude = mag_reg;

endmodule

### src/cordic_vectoring_atan_magnitude.sv
// ----------------------------------------------------------------------------
// cordic_vectoring_atan_magnitude
// pipelined cordic vectoring: angle and length of a signed vector
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_ready carry one word (x_coord, y_coord).
//   output channel: out_valid / out_ready carry one word (angle_deg, magnitude),
//   angle in degrees * 65536, clamped to -5900000 .. 17700000.
//   stages: one fold stage, 20 rotation cells, one gain multiply stage, one
//   output register.
//   throughput: one word per cycle while out_ready stays high; every stage is a
//   register in the cell chain and each cell performs one shift-add rotation.
//   each stage has its own valid bit and takes a new word when it is empty or
//   when its word moves on, so bubbles close up and a new word is accepted
//   while a finished result waits at the output.
//   when the receiver stalls, results back up stage by stage; in_ready drops
//   only once the whole chain is full.
//   reset clears all valid bits; the pipeline is empty and in_ready is high
//   right after reset.
// ----------------------------------------------------------------------------
`include "cordic_vectoring_atan_magnitude_macros.svh"

module cordic_vectoring_atan_magnitude (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] x_coord,
    input  logic signed [15:0] y_coord,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [25:0] angle_deg,
    output logic [15:0]        magnitude
);

    cvam_pkg::data_t cell_data  [cvam_pkg::ITERATIONS+1];
    logic            cell_valid [cvam_pkg::ITERATIONS+1];
    logic            cell_ready [cvam_pkg::ITERATIONS+1];

    // fold stage
    cvam_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .out_valid (cell_valid[0]),
        .out_ready (cell_ready[0]),
        .out_data  (cell_data[0])
    );

    // chain of rotation cells, cell i shifts by i
    for (genvar i = 0; i < cvam_pkg::ITERATIONS; i++) begin : g_cell
        cvam_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (cvam_pkg::SHIFT_W'(i)),
            .atan_step (cvam_pkg::atan_step(i)),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    // gain correction and output register
    cvam_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cell_valid[cvam_pkg::ITERATIONS]),
        .in_ready  (cell_ready[cvam_pkg::ITERATIONS]),
        .in_data   (cell_data[cvam_pkg::ITERATIONS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .angle_deg (angle_deg),
        .magnitude (magnitude)
    );

    // assertions
    `CVAM_ASSERT_ANY(a_no_out_in_reset, clk, !rst_n |-> !out_valid, "output valid during reset")
    `CVAM_ASSERT(a_angle_range, clk, rst_n, out_valid |-> (angle_deg >= -26'sd5900000 && angle_deg <= 26'sd17700000), "angle out of range")
    `CVAM_ASSERT(a_x_positive, clk, rst_n, cell_valid[cvam_pkg::ITERATIONS] |-> !cell_data[cvam_pkg::ITERATIONS].x[cvam_pkg::DATA_W-1], "final x negative")
    `CVAM_ASSERT(a_stall_only_full, clk, rst_n, !in_ready |-> cell_valid[0], "input stalled with empty fold stage")

endmodule
